// ----- hw/rtl/cnp_pkg.sv -----
// Shared types and constants for the chunk peak-to-peak note extractor.
// No dependencies; every module of the block imports this package.
package cnp_pkg;

  localparam int unsigned MAX_CHUNK_DEF = 4096;

  localparam int unsigned RATE_W  = 20;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned SAMP_W  = 16;
  localparam int unsigned NOTE_W  = 20;
  localparam int unsigned DUR_W   = 22;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(44100);
  localparam logic [THR_W-1:0]  THR_RST  = THR_W'(100);
  localparam logic [LEN_W-1:0]  LEN_RST  = LEN_W'(1024);
  localparam logic              MODE_RST = 1'b1;

  // milliseconds per second, and the bits it needs as a multiplier operand
  localparam int unsigned MS_PER_S = 1000;
  localparam int unsigned MS_W     = 10;

  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  // chunk jobs buffered between classifier and divider
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE   = 2'd0,
    CFG_AMP_THRESHOLD = 2'd1,
    CFG_CHUNK_LENGTH  = 2'd2,
    CFG_SIXTEEN_BIT   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [RATE_W-1:0] sample_rate;
    logic [THR_W-1:0]  amp_threshold;
    logic [LEN_W-1:0]  chunk_length;
    logic              sixteen_bit;
  } cfg_t;

endpackage

// ----- hw/rtl/cnp_front.sv -----
// Front end: decodes samples, tracks chunk min/max/count and queues closed chunks above the threshold.
// Depends on cnp_pkg.
module cnp_front import cnp_pkg::*; #(
  parameter int unsigned MAX_CHUNK = MAX_CHUNK_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_CHUNK + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SAMP_W-1:0] in_raw_sample,
  input  logic              in_end_of_stream,
  output logic              job_push,
  output logic [THR_W-1:0]  job_amp,
  output logic [CNT_W-1:0]  job_cnt,
  input  logic              job_full
);

  localparam int unsigned LW = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic [CNT_W-1:0]         samples_r, samples_nxt;
  logic [CNT_W-1:0]         cnt_done_r;
  logic                     pend_r;
  logic signed [SAMP_W-1:0] max_r, min_r, max_nxt, min_nxt;
  logic signed [SAMP_W-1:0] samp;
  logic [CNT_W-1:0]         cnt_inc;
  logic [LW-1:0]            len_x, eff_len;
  logic                     accept, first, close;
  logic [SAMP_W:0]          diff;

  // 8-bit mode: byte minus 128 is the byte with its top bit flipped, sign-extended
  assign samp = cfg.sixteen_bit ? $signed(in_raw_sample)
                                : $signed({{8{~in_raw_sample[7]}}, ~in_raw_sample[7],
                                           in_raw_sample[6:0]});

  assign in_stall = pend_r && job_full;
  assign accept   = in_valid && !in_stall;
  assign first    = (samples_r == '0);
  assign cnt_inc  = samples_r + CNT_W'(1);

  assign len_x   = LW'(cfg.chunk_length);
  assign eff_len = (len_x == '0) ? LW'(1) :
                   (len_x > LW'(MAX_CHUNK)) ? LW'(MAX_CHUNK) : len_x;
  assign close   = in_end_of_stream || (LW'(cnt_inc) >= eff_len);

  assign max_nxt     = (first || samp > max_r) ? samp : max_r;
  assign min_nxt     = (first || samp < min_r) ? samp : min_r;
  assign samples_nxt = close ? '0 : cnt_inc;

  // extremes of a closed chunk stay put while it is pending; amplitude is taken then
  assign diff     = {max_r[SAMP_W-1], max_r} - {min_r[SAMP_W-1], min_r};
  assign job_amp  = diff[THR_W-1:0];
  assign job_cnt  = cnt_done_r;
  assign job_push = pend_r && !job_full && (job_amp > cfg.amp_threshold);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r <= '0;
      pend_r    <= 1'b0;
      max_r     <= '0;
      min_r     <= '0;
    end else if (accept) begin
      samples_r  <= samples_nxt;
      max_r      <= max_nxt;
      min_r      <= min_nxt;
      cnt_done_r <= cnt_inc;
      pend_r     <= close;
    end else if (pend_r && !job_full) begin
      pend_r <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    samples_r < CNT_W'(MAX_CHUNK))
    else $error("chunk sample count out of range");

  a_close_held: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && job_full |=> pend_r && $stable(max_r) && $stable(min_r))
    else $error("closed chunk lost while queue full");

endmodule

// ----- hw/rtl/cnp_fifo.sv -----
// Small job queue between the chunk classifier and the divider.
// Depends on cnp_pkg for its default depth.
module cnp_fifo import cnp_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] fill_r;

  assign full     = (fill_r == CW'(DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CW'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("job queue underflow");

endmodule

// ----- hw/rtl/cnp_back.sv -----
// Back end: one shared restoring divider computes note value and duration per chunk job,
// then holds the result in an output register. Depends on cnp_pkg.
module cnp_back import cnp_pkg::*; #(
  parameter int unsigned MAX_CHUNK = MAX_CHUNK_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_CHUNK + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              job_empty,
  output logic              job_pop,
  input  logic [THR_W-1:0]  job_amp,
  input  logic [CNT_W-1:0]  job_cnt,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NOTE_W-1:0] out_note_value,
  output logic [DUR_W-1:0]  out_duration_ms
);

  localparam int unsigned PROD_W = CNT_W + MS_W;
  localparam int unsigned NUM_W  = (PROD_W > RATE_W) ? PROD_W : RATE_W;
  localparam int unsigned STEP_W = $clog2(NUM_W + 1);
  localparam int unsigned QX_W   = NUM_W + DUR_W;

  typedef enum logic [1:0] {ST_IDLE, ST_NOTE, ST_DUR, ST_DONE} state_t;

  state_t              state_r;
  logic [NUM_W-1:0]    num_r;
  logic [RATE_W-1:0]   rem_r, dvs_r;
  logic [STEP_W-1:0]   step_r;
  logic [PROD_W-1:0]   prod_r;
  logic [NOTE_W-1:0]   note_r, out_note_r;
  logic [DUR_W-1:0]    dur_r, out_dur_r;
  logic                out_valid_r;

  logic [RATE_W:0]     shifted, trial;
  logic                ge;
  logic [RATE_W-1:0]   rem_step;
  logic [NUM_W-1:0]    num_step;
  logic [QX_W-1:0]     q_ext;
  logic [DUR_W-1:0]    dur_sat;
  logic                last_step, out_take;

  // one quotient bit per cycle; num_r shifts dividend out and quotient in
  assign shifted  = {rem_r, num_r[NUM_W-1]};
  assign trial    = shifted - {1'b0, dvs_r};
  assign ge       = !trial[RATE_W];
  assign rem_step = ge ? trial[RATE_W-1:0] : shifted[RATE_W-1:0];
  assign num_step = {num_r[NUM_W-2:0], ge};

  assign q_ext   = QX_W'(num_step);
  assign dur_sat = (|q_ext[QX_W-1:DUR_W]) ? DUR_MAX : q_ext[DUR_W-1:0];

  assign last_step = (step_r == STEP_W'(NUM_W - 1));
  assign out_take  = out_valid_r && !out_stall;
  assign job_pop   = (state_r == ST_IDLE) && !job_empty;

  assign out_valid       = out_valid_r;
  assign out_note_value  = out_note_r;
  assign out_duration_ms = out_dur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // in ST_DONE a taken word is replaced by the next one below
      if (out_take && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!job_empty) begin
            prod_r <= PROD_W'(job_cnt) * PROD_W'(MS_PER_S);
            if (cfg.sample_rate == '0) begin
              note_r  <= '0;
              dur_r   <= DUR_MAX;
              state_r <= ST_DONE;
            end else begin
              num_r   <= NUM_W'(cfg.sample_rate);
              rem_r   <= '0;
              dvs_r   <= RATE_W'(job_amp);
              step_r  <= '0;
              state_r <= ST_NOTE;
            end
          end
        end
        ST_NOTE: begin
          if (last_step) begin
            note_r  <= num_step[NOTE_W-1:0];
            num_r   <= NUM_W'(prod_r);
            rem_r   <= '0;
            dvs_r   <= cfg.sample_rate;
            step_r  <= '0;
            state_r <= ST_DUR;
          end else begin
            num_r  <= num_step;
            rem_r  <= rem_step;
            step_r <= step_r + STEP_W'(1);
          end
        end
        ST_DUR: begin
          num_r  <= num_step;
          rem_r  <= rem_step;
          step_r <= step_r + STEP_W'(1);
          if (last_step) begin
            dur_r   <= dur_sat;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || out_take) begin
            out_note_r  <= note_r;
            out_dur_r   <= dur_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NOTE || state_r == ST_DUR) |-> step_r < STEP_W'(NUM_W))
    else $error("divider step count out of range");

  a_done_drains: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && !out_valid_r |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished result not moved to output register");

endmodule

// ----- hw/rtl/chunk_peak_to_peak_note_extractor_unit.sv -----
// Throughput: one sample per cycle; in_stall rises only while the 4-entry chunk queue is full.
// Each chunk result runs two divisions of an N-bit dividend, N = max(20, clog2(MAX_CHUNK+1)+10) (23 default).
// Closed chunks pass the job queue, both divisions (none if sample_rate is 0) and the output register.
// The divider is one shared restoring unit used for note value, then duration.
// Synchronous active-low reset loads register defaults and empties the chunk and queue.
module chunk_peak_to_peak_note_extractor_unit import cnp_pkg::*; #(
  parameter int unsigned MAX_CHUNK = MAX_CHUNK_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMP_W-1:0]    in_raw_sample,
  input  logic                 in_end_of_stream,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [NOTE_W-1:0]    out_note_value,
  output logic [DUR_W-1:0]     out_duration_ms
);

  localparam int unsigned CNT_W = $clog2(MAX_CHUNK + 1);
  localparam int unsigned JOB_W = THR_W + CNT_W;

  cfg_t             cfg_r;
  logic             job_push, job_full, job_pop, job_empty;
  logic [THR_W-1:0] push_amp, pop_amp;
  logic [CNT_W-1:0] push_cnt, pop_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_rate   <= RATE_RST;
      cfg_r.amp_threshold <= THR_RST;
      cfg_r.chunk_length  <= LEN_RST;
      cfg_r.sixteen_bit   <= MODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SAMPLE_RATE:   cfg_r.sample_rate   <= cfg_wdata;
        CFG_AMP_THRESHOLD: cfg_r.amp_threshold <= cfg_wdata[THR_W-1:0];
        CFG_CHUNK_LENGTH:  cfg_r.chunk_length  <= cfg_wdata[LEN_W-1:0];
        CFG_SIXTEEN_BIT:   cfg_r.sixteen_bit   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  cnp_front #(.MAX_CHUNK(MAX_CHUNK)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_sample    (in_raw_sample),
    .in_end_of_stream (in_end_of_stream),
    .job_push         (job_push),
    .job_amp          (push_amp),
    .job_cnt          (push_cnt),
    .job_full         (job_full)
  );

  cnp_fifo #(.W(JOB_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data ({push_amp, push_cnt}),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  ({pop_amp, pop_cnt}),
    .empty     (job_empty)
  );

  cnp_back #(.MAX_CHUNK(MAX_CHUNK)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .job_empty       (job_empty),
    .job_pop         (job_pop),
    .job_amp         (pop_amp),
    .job_cnt         (pop_cnt),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_note_value  (out_note_value),
    .out_duration_ms (out_duration_ms)
  );

endmodule
